/* hdl/sbsh_pkg.sv */
// Shared constants, types and round functions of the SHA-256 byte stream hasher.
package sbsh_pkg;

    localparam int unsigned ROUND_COUNT  = 64;
    localparam int unsigned DIGEST_WORDS = 8;

    localparam logic [5:0] LAST_ROUND    = 6'(ROUND_COUNT - 1);
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
    localparam logic [2:0] LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);
    localparam logic [7:0] PAD_BYTE      = 8'h80;

    typedef logic [0:7][31:0] t_chain;

    localparam t_chain INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUND_COUNT] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } t_core_state;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_COMPRESS,
        ST_PAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;     // shift one byte into the block window
        logic [7:0] data;
        logic       start;    // begin compressing the loaded block
        logic       iv_load;  // restore the initial hash for the next message
    } t_core_ctl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* hdl/sbsh_sched.sv */
// Message schedule: a 16-word window that takes bytes in and expands words per round.
module sbsh_sched (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [7:0]  i_byte,
    input  logic        i_shift,
    output logic [31:0] o_wt
);
    import sbsh_pkg::*;

    // Oldest word sits in the top 32 bits.
    logic [511:0] r_win;
    logic [31:0]  w_new;

    always_comb begin
        w_new = ssig1(r_win[63:32]) + r_win[223:192] + ssig0(r_win[479:448])
              + r_win[511:480];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= {r_win[503:0], i_byte};
        end else if (i_shift) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

    assign o_wt = r_win[511:480];

endmodule

/* hdl/sbsh_core.sv */
// Compression engine: one SHA-256 round per cycle, reused 64 times, plus the chain add.
module sbsh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbsh_pkg::t_core_ctl i_ctl,
    output logic               o_done,
    output sbsh_pkg::t_chain   o_chain
);
    import sbsh_pkg::*;

    t_core_state r_state, n_state;
    logic [5:0]  r_round;
    t_chain      r_chain;
    t_chain      r_v;
    logic        w_shift;
    logic [31:0] w_wt, w_t1, w_t2, w_ch, w_maj;

    sbsh_sched u_sched (
        .i_clk   (i_clk),
        .i_load  (i_ctl.load),
        .i_byte  (i_ctl.data),
        .i_shift (w_shift),
        .o_wt    (w_wt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            CORE_IDLE:  if (i_ctl.start) n_state = CORE_ROUND;
            CORE_ROUND: if (r_round == LAST_ROUND) n_state = CORE_ADD;
            CORE_ADD:   n_state = CORE_IDLE;
            default:    n_state = CORE_IDLE;
        endcase
    end

    always_comb begin
        w_shift = 1'b0;
        o_done  = 1'b0;
        case (r_state)
            CORE_ROUND: w_shift = 1'b1;
            CORE_ADD:   o_done  = 1'b1;
            default: begin
                w_shift = 1'b0;
                o_done  = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1  = r_v[7] + bsig1(r_v[4]) + w_ch + ROUND_K[r_round] + w_wt;
        w_t2  = bsig0(r_v[0]) + w_maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_round <= '0;
            r_chain <= INIT_HASH;
        end else begin
            r_state <= n_state;
            if (i_ctl.start) begin
                r_round <= '0;
            end else if (r_state == CORE_ROUND) begin
                r_round <= r_round + 6'd1;
            end
            if (i_ctl.iv_load) begin
                r_chain <= INIT_HASH;
            end else if (r_state == CORE_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
        end
    end

    // Working variables a..h.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_chain;
        end else if (r_state == CORE_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    assign o_chain = r_chain;

endmodule

/* hdl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher: byte intake, padding sequencer and digest output.
//
// Each accepted word on the slave side carries at most one message byte (tuser high) and
// tlast closes the message. Bytes are shifted straight into the schedule window; when 64
// have arrived the block stops taking words and one shared round unit runs the 64 rounds,
// one per cycle, followed by the chain add. On tlast the sequencer writes the padding
// itself, one byte per cycle (0x80, zeros, then the 64-bit big-endian bit length),
// compressing one or two more blocks; the second is needed when the length no longer fits
// the open block. The digest then leaves on the master side as eight 32-bit words, word
// index in tuser, tlast on the eighth, and the hasher rearms for the next message. A word
// with neither a byte nor tlast is taken and ignored. An empty message is a single word
// with tlast high and tuser low.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] has_byte
    input  logic        i_s_axis_tlast,   // end_of_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  o_m_axis_tuser,   // [2:0] word_index
    output logic        o_m_axis_tlast    // last_word
);
    import sbsh_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_pos;
    logic [60:0] r_count;
    logic [2:0]  r_widx;
    logic        r_pad_first;  // 0x80 still to be written
    logic        r_final;      // current pad block carries the length
    logic        r_last_blk;   // block under compression is the last one
    logic        r_eom_pend;   // message ended, padding still owed

    t_core_ctl   w_ctl;
    logic        w_done;
    t_chain      w_chain;
    logic        w_in_acc, w_out_acc, w_go, w_eff_final;
    logic [63:0] w_len;
    logic [2:0]  w_lidx;
    logic [7:0]  w_len_byte, w_pad_byte;

    sbsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_done  (w_done),
        .o_chain (w_chain)
    );

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // Length bytes go out most significant first at positions 56..63.
    assign w_len      = {r_count, 3'b000};
    assign w_lidx     = 3'd7 - r_pos[2:0];
    assign w_len_byte = w_len[{w_lidx, 3'b000} +: 8];

    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = PAD_BYTE;
        end else if (r_final && (r_pos >= LEN_BYTE_POS)) begin
            w_pad_byte = w_len_byte;
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // The 0x80 byte decides whether the length still fits this block.
    assign w_eff_final = r_pad_first ? (r_pos < LEN_BYTE_POS) : r_final;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser && (r_pos == LAST_BYTE_POS)) begin
                        n_state = ST_COMPRESS;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_COMPRESS: begin
                if (w_done) begin
                    if (r_last_blk) begin
                        n_state = ST_OUT;
                    end else if (r_eom_pend) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_COLLECT;
                    end
                end
            end
            ST_PAD: begin
                if (r_pos == LAST_BYTE_POS) n_state = ST_COMPRESS;
            end
            ST_OUT: begin
                if (w_out_acc && (r_widx == LAST_WORD_IDX)) n_state = ST_COLLECT;
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        w_ctl           = '0;
        w_go            = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_s_axis_tready = 1'b1;
                w_ctl.load      = w_in_acc && i_s_axis_tuser;
                w_ctl.data      = i_s_axis_tdata;
                w_go            = w_in_acc && i_s_axis_tuser && (r_pos == LAST_BYTE_POS);
            end
            ST_PAD: begin
                w_ctl.load = 1'b1;
                w_ctl.data = w_pad_byte;
                w_go       = (r_pos == LAST_BYTE_POS);
            end
            ST_OUT: begin
                o_m_axis_tvalid = 1'b1;
                w_ctl.iv_load   = w_out_acc && (r_widx == LAST_WORD_IDX);
            end
            default: begin
                o_s_axis_tready = 1'b0;
                o_m_axis_tvalid = 1'b0;
            end
        endcase
        w_ctl.start = w_go;
    end

    assign o_m_axis_tdata = w_chain[r_widx];
    assign o_m_axis_tuser = r_widx;
    assign o_m_axis_tlast = (r_widx == LAST_WORD_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_pos       <= '0;
            r_count     <= '0;
            r_widx      <= '0;
            r_pad_first <= 1'b0;
            r_final     <= 1'b0;
            r_last_blk  <= 1'b0;
            r_eom_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (i_s_axis_tuser) begin
                    r_pos   <= r_pos + 6'd1;
                    r_count <= r_count + 61'd1;
                end
                r_eom_pend <= i_s_axis_tlast;
                if (i_s_axis_tlast) begin
                    r_pad_first <= 1'b1;
                    r_final     <= 1'b0;
                end
                if (w_go) r_last_blk <= 1'b0;
            end
            if (r_state == ST_PAD) begin
                r_pos       <= r_pos + 6'd1;
                r_pad_first <= 1'b0;
                if (w_go) begin
                    r_last_blk <= w_eff_final;
                    r_final    <= 1'b1;
                end else if (r_pad_first) begin
                    r_final <= w_eff_final;
                end
            end
            if (w_out_acc) begin
                r_widx <= r_widx + 3'd1;
                if (r_widx == LAST_WORD_IDX) begin
                    r_count    <= '0;
                    r_eom_pend <= 1'b0;
                end
            end
        end
    end

    // Intake and digest output never overlap.
    a_excl_sides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("intake and output active together");

    // The round engine only finishes while the sequencer waits for it.
    a_done_in_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_COMPRESS))
        else $error("compression finished outside compress state");

    // Padding writes one byte every cycle.
    a_pad_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |=> (r_pos == 6'($past(r_pos) + 6'd1)))
        else $error("pad position did not advance");

    // After the eighth digest word the hasher is ready for a new message at byte zero.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (o_s_axis_tready && (r_pos == 6'd0)
                                           && (r_count == 61'd0)))
        else $error("hasher did not rearm after digest");

endmodule
